// File: hdl/svf_pkg.sv
`default_nettype none

package svf_pkg;

    localparam int COEF_W     = 18;
    localparam int COEF_FRAC  = 16;
    localparam int DIGIT_W    = 12;
    localparam int A_W        = 17;
    localparam int K_W        = 18;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 18;

    localparam logic [CFG_ADDR_W-1:0] REG_A1   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_A2   = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_A3   = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_K    = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE = 3'd4;

    localparam logic [A_W-1:0] A1_RST = 17'd32768;
    localparam logic [A_W-1:0] A2_RST = 17'd16384;
    localparam logic [A_W-1:0] A3_RST = 17'd8192;
    localparam logic [K_W-1:0] K_RST  = 18'd131072;

    typedef enum logic [1:0] {
        MODE_LOW,
        MODE_HIGH,
        MODE_BAND,
        MODE_NOTCH
    } t_mode;

    typedef struct packed {
        logic load;
        logic step;
        logic last;
    } t_lane_ctl;

endpackage

`default_nettype wire

// File: hdl/svf_dsm.sv
`default_nettype none

module svf_dsm #(
    parameter int OP_W = 36
) (
    input  logic                            i_clk,
    input  svf_pkg::t_lane_ctl              i_ctl,
    input  logic [svf_pkg::COEF_W-1:0]      i_coef,
    input  logic signed [OP_W-1:0]          i_operand,
    output logic signed [OP_W+1:0]          o_product
);
    import svf_pkg::*;

    localparam int NDIG  = (OP_W + DIGIT_W - 1) / DIGIT_W;
    localparam int SH_W  = NDIG * DIGIT_W;
    localparam int ACC_W = COEF_W + DIGIT_W + 2;
    localparam int RES_W = OP_W + 2;

    logic [COEF_W-1:0]       r_coef;
    logic [SH_W-1:0]         r_op;
    logic signed [ACC_W-1:0] r_acc;
    logic [SH_W-1:0]         r_low;

    logic signed [DIGIT_W:0]    w_digit;
    logic signed [ACC_W-1:0]    w_prod;
    logic signed [ACC_W-1:0]    w_sum;
    logic [ACC_W+SH_W-1:0]      w_full;

    // top digit of the operand carries the sign
    assign w_digit = {i_ctl.last & r_op[DIGIT_W-1], r_op[DIGIT_W-1:0]};
    assign w_prod  = ACC_W'($signed({1'b0, r_coef})) * ACC_W'(w_digit);
    assign w_sum   = r_acc + w_prod;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_coef <= i_coef;
            r_op   <= SH_W'(i_operand);
            r_acc  <= '0;
        end else if (i_ctl.step) begin
            r_acc <= w_sum >>> DIGIT_W;
            r_low <= {w_sum[DIGIT_W-1:0], r_low[SH_W-1:DIGIT_W]};
            r_op  <= r_op >> DIGIT_W;
        end
    end

    // drop the fractional bits of the coefficient
    assign w_full    = {r_acc, r_low};
    assign o_product = $signed(w_full[COEF_FRAC +: RES_W]);

endmodule

`default_nettype wire

// File: hdl/state_variable_filter.sv
// Second-order trapezoidal state-variable filter, one sample word in, one result word out.
// Input channel s_axis: a signed sample per word. Output channel m_axis: the selected
// response followed by lowpass, highpass, bandpass and notch, each saturated to the
// sample width. Coefficients a1, a2, a3, k and the mode are loaded through the write
// port (i_cfg_we, i_cfg_addr, i_cfg_wdata); the user must load them only while the
// filter is idle, the block itself does not enforce this. Each sample runs two
// digit-serial multiply passes over NDIG = ceil((max(SAMPLE_WIDTH,STATE_WIDTH)+4)/12)
// digits, 12 bits of operand per cycle: the four coefficient products run in parallel
// lanes, then the k*v1 product reuses the first lane once v1 is known.
// An accepted word runs S_MULA, S_SUM, S_MULB, then S_FIN, which raises m_axis_tvalid.
// A finished word sits in the output register; the next sample is accepted while it
// waits. If the receiver still holds off when the next word is done, the filter holds
// that word and its state update until the output register frees.
// Reset loads the default coefficients and lowpass mode and clears both integrators;
// no clearing pass follows, the first sample is taken in the cycle after reset.
`default_nettype none

module state_variable_filter #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int STATE_WIDTH  = 32
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [svf_pkg::CFG_ADDR_W-1:0]         i_cfg_addr,
    input  logic [svf_pkg::CFG_DATA_W-1:0]         i_cfg_wdata,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // sample_in
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // selected_out, low_out, high_out, band_out, notch_out
    output logic [((5*SAMPLE_WIDTH+7)/8)*8-1:0]    m_axis_tdata
);
    import svf_pkg::*;

    localparam int SW     = SAMPLE_WIDTH;
    localparam int TW     = STATE_WIDTH;
    localparam int MW     = (SW > TW) ? SW : TW;
    localparam int OP_W   = MW + 4;
    localparam int P_W    = OP_W + 2;
    localparam int E_W    = MW + 8;
    localparam int NDIG   = (OP_W + DIGIT_W - 1) / DIGIT_W;
    localparam int DIG_CW = (NDIG > 1) ? $clog2(NDIG) : 1;
    localparam int OUT_W  = ((5 * SW + 7) / 8) * 8;

    localparam logic signed [E_W-1:0] SMP_MAX = {{(E_W-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [E_W-1:0] SMP_MIN = {{(E_W-SW+1){1'b1}}, {(SW-1){1'b0}}};
    localparam logic signed [E_W-1:0] ST_MAX  = {{(E_W-TW+1){1'b0}}, {(TW-1){1'b1}}};
    localparam logic signed [E_W-1:0] ST_MIN  = {{(E_W-TW+1){1'b1}}, {(TW-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULA,
        S_SUM,
        S_MULB,
        S_FIN
    } t_state;

    function automatic logic signed [SW-1:0] sat_smp(input logic signed [E_W-1:0] v);
        if (v > SMP_MAX) begin
            return SMP_MAX[SW-1:0];
        end else if (v < SMP_MIN) begin
            return SMP_MIN[SW-1:0];
        end
        return v[SW-1:0];
    endfunction

    function automatic logic signed [TW-1:0] sat_st(input logic signed [E_W-1:0] v);
        if (v > ST_MAX) begin
            return ST_MAX[TW-1:0];
        end else if (v < ST_MIN) begin
            return ST_MIN[TW-1:0];
        end
        return v[TW-1:0];
    endfunction

    t_state                  r_state;
    logic [DIG_CW-1:0]       r_dig;
    logic [A_W-1:0]          r_a1;
    logic [A_W-1:0]          r_a2;
    logic [A_W-1:0]          r_a3;
    logic [K_W-1:0]          r_k;
    t_mode                   r_mode;
    logic signed [TW-1:0]    r_s1;
    logic signed [TW-1:0]    r_s2;
    logic signed [SW-1:0]    r_x;
    logic signed [OP_W-1:0]  r_v1;
    logic signed [E_W-1:0]   r_v2;
    logic signed [E_W-1:0]   r_xmv2;
    logic                    r_out_valid;
    logic signed [SW-1:0]    r_sel;
    logic signed [SW-1:0]    r_lo;
    logic signed [SW-1:0]    r_hi;
    logic signed [SW-1:0]    r_bd;
    logic signed [SW-1:0]    r_nt;

    logic                    w_in_acc;
    logic                    w_last;
    logic                    w_slot_free;
    logic signed [SW-1:0]    w_x_in;
    logic signed [MW:0]      w_v3;
    logic [OP_W-1:0]         w_op0;
    logic [COEF_W-1:0]       w_coef0;
    logic signed [P_W-1:0]   w_p [4];
    logic signed [E_W-1:0]   w_v1;
    logic signed [E_W-1:0]   w_v2;
    logic signed [E_W-1:0]   w_notch;
    logic signed [E_W-1:0]   w_high;
    logic signed [E_W-1:0]   w_ns1;
    logic signed [E_W-1:0]   w_ns2;
    logic signed [SW-1:0]    w_lo_s;
    logic signed [SW-1:0]    w_hi_s;
    logic signed [SW-1:0]    w_bd_s;
    logic signed [SW-1:0]    w_nt_s;
    logic signed [SW-1:0]    w_sel;
    t_lane_ctl               w_ctl_0;
    t_lane_ctl               w_ctl_a;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_last        = (r_dig == DIG_CW'(NDIG - 1));
    assign w_slot_free   = !r_out_valid || m_axis_tready;
    assign w_x_in        = $signed(s_axis_tdata[SW-1:0]);
    assign w_v3          = (MW+1)'(w_x_in) - (MW+1)'(r_s2);

    always_comb begin
        w_ctl_a.load = w_in_acc;
        w_ctl_a.step = (r_state == S_MULA);
        w_ctl_a.last = w_last;
        w_ctl_0.load = w_in_acc || (r_state == S_SUM);
        w_ctl_0.step = (r_state == S_MULA) || (r_state == S_MULB);
        w_ctl_0.last = w_last;
    end

    // first lane: a1*s1, then k*v1
    assign w_op0   = (r_state == S_SUM) ? w_v1[OP_W-1:0] : OP_W'(r_s1);
    assign w_coef0 = (r_state == S_SUM) ? r_k : COEF_W'(r_a1);

    svf_dsm #(.OP_W(OP_W)) u_lane0 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl_0),
        .i_coef    (w_coef0),
        .i_operand (w_op0),
        .o_product (w_p[0])
    );

    svf_dsm #(.OP_W(OP_W)) u_lane1 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl_a),
        .i_coef    (COEF_W'(r_a2)),
        .i_operand (OP_W'(w_v3)),
        .o_product (w_p[1])
    );

    svf_dsm #(.OP_W(OP_W)) u_lane2 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl_a),
        .i_coef    (COEF_W'(r_a2)),
        .i_operand (OP_W'(r_s1)),
        .o_product (w_p[2])
    );

    svf_dsm #(.OP_W(OP_W)) u_lane3 (
        .i_clk     (i_clk),
        .i_ctl     (w_ctl_a),
        .i_coef    (COEF_W'(r_a3)),
        .i_operand (OP_W'(w_v3)),
        .o_product (w_p[3])
    );

    assign w_v1    = E_W'(w_p[0]) + E_W'(w_p[1]);
    assign w_v2    = E_W'(r_s2) + E_W'(w_p[2]) + E_W'(w_p[3]);
    assign w_notch = E_W'(r_x) - E_W'(w_p[0]);
    assign w_high  = r_xmv2 - E_W'(w_p[0]);
    assign w_ns1   = (E_W'(r_v1) <<< 1) - E_W'(r_s1);
    assign w_ns2   = (r_v2 <<< 1) - E_W'(r_s2);
    assign w_lo_s  = sat_smp(r_v2);
    assign w_hi_s  = sat_smp(w_high);
    assign w_bd_s  = sat_smp(E_W'(r_v1));
    assign w_nt_s  = sat_smp(w_notch);

    always_comb begin
        unique case (r_mode)
            MODE_LOW:   w_sel = w_lo_s;
            MODE_HIGH:  w_sel = w_hi_s;
            MODE_BAND:  w_sel = w_bd_s;
            MODE_NOTCH: w_sel = w_nt_s;
            default:    w_sel = w_lo_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a1   <= A1_RST;
            r_a2   <= A2_RST;
            r_a3   <= A3_RST;
            r_k    <= K_RST;
            r_mode <= MODE_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                REG_A1:   r_a1   <= i_cfg_wdata[A_W-1:0];
                REG_A2:   r_a2   <= i_cfg_wdata[A_W-1:0];
                REG_A3:   r_a3   <= i_cfg_wdata[A_W-1:0];
                REG_K:    r_k    <= i_cfg_wdata[K_W-1:0];
                REG_MODE: r_mode <= t_mode'(i_cfg_wdata[1:0]);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_dig       <= '0;
            r_out_valid <= 1'b0;
            r_s1        <= '0;
            r_s2        <= '0;
        end else begin
            if (m_axis_tready && (r_state != S_FIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_x     <= w_x_in;
                        r_dig   <= '0;
                        r_state <= S_MULA;
                    end
                end
                S_MULA: begin
                    if (w_last) begin
                        r_dig   <= '0;
                        r_state <= S_SUM;
                    end else begin
                        r_dig <= r_dig + DIG_CW'(1);
                    end
                end
                S_SUM: begin
                    r_v1    <= w_v1[OP_W-1:0];
                    r_v2    <= w_v2;
                    r_state <= S_MULB;
                end
                S_MULB: begin
                    r_xmv2 <= E_W'(r_x) - r_v2;
                    if (w_last) begin
                        r_dig   <= '0;
                        r_state <= S_FIN;
                    end else begin
                        r_dig <= r_dig + DIG_CW'(1);
                    end
                end
                S_FIN: begin
                    // hold until the output register frees
                    if (w_slot_free) begin
                        r_out_valid <= 1'b1;
                        r_sel       <= w_sel;
                        r_lo        <= w_lo_s;
                        r_hi        <= w_hi_s;
                        r_bd        <= w_bd_s;
                        r_nt        <= w_nt_s;
                        r_s1        <= sat_st(w_ns1);
                        r_s2        <= sat_st(w_ns2);
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'({r_nt, r_bd, r_hi, r_lo, r_sel});

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_state == S_MULA) && (r_dig == '0))
        else $error("accepted word did not start the first multiply pass");

    a_dig_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_dig <= DIG_CW'(NDIG - 1)) &&
        ((r_state == S_MULA) || (r_state == S_MULB) || (r_dig == '0)))
        else $error("digit counter out of range");

    a_result_from_fin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $rose(r_out_valid) |-> $past(r_state) == S_FIN)
        else $error("result word raised outside the final step");

    a_state_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && (!$stable(r_s1) || !$stable(r_s2)) |->
        ($past(r_state) == S_FIN) && $past(w_slot_free))
        else $error("integrator changed outside the final step");

endmodule

`default_nettype wire

// File: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import svf_pkg::*;

    localparam int SAMPLE_W    = 16;
    localparam int STATE_W     = 32;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 75;

    typedef logic [SAMPLE_W-1:0]   t_sample;
    typedef logic [CFG_DATA_W-1:0] t_cfg_word;

    typedef struct {
        t_sample sel;
        t_sample low;
        t_sample high;
        t_sample band;
        t_sample notch;
    } t_response;

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = '0;
    t_cfg_word             i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    t_sample               s_axis_tdata  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [5*SAMPLE_W-1:0] m_axis_tdata;

    // predictor copy of the registers and integrators
    logic [A_W-1:0] cur_a1;
    logic [A_W-1:0] cur_a2;
    logic [A_W-1:0] cur_a3;
    logic [K_W-1:0] cur_k;
    t_mode          cur_mode;
    longint         band_acc;
    longint         low_acc;

    t_response pending_responses[$];
    int        error_count = 0;
    int        burst_left  = 0;
    int        hold_req    = 0;
    int        hold_seen   = 0;
    int        hold_left   = 0;
    int        stall_style = 0;
    int        stall_left  = 0;

    state_variable_filter dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 i_clk = ~i_clk;

    function automatic longint coef_mul(longint c, longint v);
        return (c * v) >>> COEF_FRAC;
    endfunction

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) begin
            return hi;
        end
        if (v < lo) begin
            return lo;
        end
        return v;
    endfunction

    function automatic t_response advance_filter(t_sample x_bits);
        longint    x;
        longint    s1;
        longint    s2;
        longint    v3;
        longint    v1;
        longint    v2;
        longint    hp;
        t_response r;
        x  = longint'($signed(x_bits));
        s1 = band_acc;
        s2 = low_acc;
        v3 = x - s2;
        v1 = coef_mul(longint'(cur_a1), s1) + coef_mul(longint'(cur_a2), v3);
        v2 = s2 + coef_mul(longint'(cur_a2), s1) + coef_mul(longint'(cur_a3), v3);
        hp = x - coef_mul(longint'(cur_k), v1) - v2;
        band_acc = clamp(2 * v1 - s1, STATE_W);
        low_acc  = clamp(2 * v2 - s2, STATE_W);
        r.low   = t_sample'(clamp(v2, SAMPLE_W));
        r.high  = t_sample'(clamp(hp, SAMPLE_W));
        r.band  = t_sample'(clamp(v1, SAMPLE_W));
        r.notch = t_sample'(clamp(v2 + hp, SAMPLE_W));
        case (cur_mode)
            MODE_HIGH:  r.sel = r.high;
            MODE_BAND:  r.sel = r.band;
            MODE_NOTCH: r.sel = r.notch;
            default:    r.sel = r.low;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        error_count++;
    endtask

    task automatic check_field(string name, t_sample got, t_sample want);
        if (got !== want) begin
            report_mismatch($sformatf("%s got %0d expected %0d", name, $signed(got),
                                      $signed(want)));
        end
    endtask

    always @(posedge i_clk) begin : check_responses
        t_response want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_responses.size() == 0) begin
                report_mismatch("response word with none outstanding");
            end else begin
                want = pending_responses.pop_front();
                check_field("selected", m_axis_tdata[0*SAMPLE_W +: SAMPLE_W], want.sel);
                check_field("low",      m_axis_tdata[1*SAMPLE_W +: SAMPLE_W], want.low);
                check_field("high",     m_axis_tdata[2*SAMPLE_W +: SAMPLE_W], want.high);
                check_field("band",     m_axis_tdata[3*SAMPLE_W +: SAMPLE_W], want.band);
                check_field("notch",    m_axis_tdata[4*SAMPLE_W +: SAMPLE_W], want.notch);
            end
        end
    end

    // receiver: changing stall pattern, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_style = $urandom_range(0, 3);
                stall_left  = $urandom_range(8, 80);
            end
            stall_left--;
            case (stall_style)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
                2:       m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= ~m_axis_tready;
            endcase
        end
    end

    // call at a falling edge; returns at a falling edge
    task automatic send_sample(t_sample x);
        s_axis_tdata  <= x;
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        pending_responses.push_back(advance_filter(x));
        @(negedge i_clk);
        burst_left--;
        if (burst_left <= 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
            burst_left = $urandom_range(1, 40);
        end
    endtask

    task automatic sender_rest();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] addr, t_cfg_word data);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= addr;
        i_cfg_wdata <= data;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        case (addr)
            REG_A1:   cur_a1   = data[A_W-1:0];
            REG_A2:   cur_a2   = data[A_W-1:0];
            REG_A3:   cur_a3   = data[A_W-1:0];
            REG_K:    cur_k    = data[K_W-1:0];
            REG_MODE: cur_mode = t_mode'(data[1:0]);
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic load_tuning(t_mode mode);
        real g;
        real kk;
        real a1r;
        g   = 0.01 + $urandom_range(0, 1000) / 1000.0;
        kk  = $urandom_range(0, 131072) / 65536.0;
        a1r = 1.0 / (1.0 + g * (g + kk));
        write_reg(REG_A1, t_cfg_word'(int'(a1r * 65536.0)));
        write_reg(REG_A2, t_cfg_word'(int'(a1r * g * 65536.0)));
        write_reg(REG_A3, t_cfg_word'(int'(a1r * g * g * 65536.0)));
        write_reg(REG_K, t_cfg_word'(int'(kk * 65536.0)));
        write_reg(REG_MODE, t_cfg_word'(mode));
    endtask

    task automatic load_flat(t_cfg_word a, t_cfg_word k, t_mode mode);
        write_reg(REG_A1, a);
        write_reg(REG_A2, a);
        write_reg(REG_A3, a);
        write_reg(REG_K, k);
        write_reg(REG_MODE, t_cfg_word'(mode));
    endtask

    task automatic test_reset_defaults();
        send_sample(16'h7FFF);
        send_sample(16'h7FFF);
        send_sample(16'h8000);
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h0001);
        sender_rest();
    endtask

    // bits above each register width, values above range, unused indexes
    task automatic test_register_masking();
        wait_drained();
        write_reg(REG_A1, t_cfg_word'(18'h3FFFF));
        write_reg(REG_A2, t_cfg_word'(18'h3FFFF));
        write_reg(REG_A3, t_cfg_word'(18'h20000));
        write_reg(REG_K, t_cfg_word'(18'h3FFFF));
        write_reg(REG_MODE, t_cfg_word'(18'h3FFFD));
        for (int a = REG_MODE + 1; a < 2 ** CFG_ADDR_W; a++) begin
            write_reg(a[CFG_ADDR_W-1:0], t_cfg_word'($urandom()));
        end
        repeat (5) send_sample(16'h7FFF);
        repeat (3) send_sample(16'h8000);
        sender_rest();
    endtask

    task automatic test_each_mode();
        wait_drained();
        write_reg(REG_A1, t_cfg_word'(A1_RST));
        write_reg(REG_A2, t_cfg_word'(A2_RST));
        write_reg(REG_A3, t_cfg_word'(A3_RST));
        write_reg(REG_K, t_cfg_word'(K_RST));
        for (int m = MODE_LOW; m <= MODE_NOTCH; m++) begin
            wait_drained();
            write_reg(REG_MODE, t_cfg_word'(m));
            send_sample(16'h7FFF);
            send_sample(16'h8000);
            send_sample(16'h04D2);
            sender_rest();
        end
    endtask

    function automatic t_sample pick_sample(int style, int idx, int amp);
        case (style)
            0:       return t_sample'($urandom());
            1:       return t_sample'($urandom_range(0, 4000) - 2000);
            2:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            default: return t_sample'(((idx / 4) % 2) ? amp : -amp);
        endcase
    endfunction

    task automatic test_random_tunings();
        int sent;
        int style;
        int run;
        int amp;
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            case (p)
                1, 5: begin
                    for (int a = REG_A1; a <= REG_MODE; a++) begin
                        write_reg(a[CFG_ADDR_W-1:0], t_cfg_word'($urandom()));
                    end
                end
                3:       load_flat(t_cfg_word'(65536), t_cfg_word'(131072), t_mode'(p % 4));
                7:       load_flat('0, '0, t_mode'(p % 4));
                default: load_tuning(t_mode'(p % 4));
            endcase
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                style = $urandom_range(0, 3);
                run   = $urandom_range(1, 20);
                amp   = $urandom_range(0, 32767);
                for (int i = 0; i < run; i++) begin
                    send_sample(pick_sample(style, i, amp));
                end
                sent += run;
            end
            sender_rest();
        end
    endtask

    // hold the receiver off while the sender keeps offering words
    task automatic test_backpressure();
        wait_drained();
        load_tuning(t_mode'($urandom_range(0, 3)));
        hold_req++;
        repeat (40) send_sample(t_sample'($urandom()));
        sender_rest();
    endtask

    initial begin
        cur_a1   = A1_RST;
        cur_a2   = A2_RST;
        cur_a3   = A3_RST;
        cur_k    = K_RST;
        cur_mode = MODE_LOW;
        band_acc = 0;
        low_acc  = 0;
        burst_left = $urandom_range(1, 40);
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_reset_defaults();
        test_register_masking();
        test_each_mode();
        test_random_tunings();
        test_backpressure();

        while (pending_responses.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (error_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d responses outstanding", pending_responses.size());
        $display("== FAIL ==");
        $finish;
    end

endmodule
